[sv/bts_pkg.sv]
// ----------------------------------------------------------------------------
// Bounded turn vector steer package
// Shared widths, types and CORDIC constants for the steering pipeline.
// ----------------------------------------------------------------------------
package bts_pkg;

    localparam int COORD_WIDTH  = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int STEPS        = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    localparam int ANGLE_W   = 16;           // binary angle, 2^16 is one turn
    localparam int ACC_W     = 32;           // vectoring accumulator, 2^32 is one turn
    localparam int TURN_W    = ANGLE_W + 1;  // signed turn after clamping
    localparam int PRE_SHIFT = 14;           // coordinates are scaled by 2^14
    localparam int XW        = COORD_WIDTH + PRE_SHIFT + 4;
    localparam int RZW       = ACC_W + 2;    // rotation residual angle
    localparam int GAIN_W    = 32;
    localparam int GAIN_SHIFT = 16;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [XW-1:0]          t_wide;
    typedef logic        [ANGLE_W-1:0]     t_angle;
    typedef logic        [ACC_W-1:0]       t_acc;
    typedef logic signed [TURN_W-1:0]      t_turn;
    typedef logic signed [RZW-1:0]         t_rz;

    localparam t_acc HALF_TURN  = t_acc'(32'h8000_0000);
    localparam t_acc ANGLE_RND  = t_acc'(32'h0000_8000);
    localparam t_turn QUARTER   = t_turn'(16384);
    localparam t_turn HALF      = t_turn'(32768);
    localparam logic [ANGLE_W-1:0] MAX_TURN_RESET = ANGLE_W'(1024);

    // 1/K in Q1.30.
    localparam logic signed [GAIN_W-1:0] INV_GAIN = 32'sd652032874;

    // round(atan(2^-i) * 2^32 / (2*pi))
    localparam t_acc ATAN_TAB [0:TABLE_LEN-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

endpackage

[sv/bts_if.sv]
// ----------------------------------------------------------------------------
// Bounded turn vector steer channels
// Valid/ready channels for vector pairs, turned headings and the turn limit.
// ----------------------------------------------------------------------------
interface bts_in_if import bts_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord heading_x;
    t_coord heading_y;
    t_coord goal_x;
    t_coord goal_y;

    modport source (output valid, heading_x, heading_y, goal_x, goal_y, input ready);
    modport sink   (input valid, heading_x, heading_y, goal_x, goal_y, output ready);
endinterface

interface bts_out_if import bts_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord turned_x;
    t_coord turned_y;

    modport source (output valid, turned_x, turned_y, input ready);
    modport sink   (input valid, turned_x, turned_y, output ready);
endinterface

interface bts_cfg_if import bts_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ANGLE_W-1:0] max_turn_angle;

    modport source (output valid, max_turn_angle, input ready);
    modport sink   (input valid, max_turn_angle, output ready);
endinterface

[sv/bts_vectoring.sv]
// ----------------------------------------------------------------------------
// CORDIC vectoring pipeline
// Finds the binary angle of one vector, one iteration per register stage.
// ----------------------------------------------------------------------------
module bts_vectoring import bts_pkg::*; (
    input  logic   i_clk,
    input  logic   i_en,
    input  t_coord i_x,
    input  t_coord i_y,
    output t_angle o_angle
);

    t_wide r_x    [0:STEPS];
    t_wide r_y    [0:STEPS];
    t_acc  r_z    [0:STEPS];
    logic  r_zero [0:STEPS];

    t_wide n_x0;
    t_wide n_y0;
    t_acc  n_z0;
    t_acc  n_rnd;

    // Vectors in the left half plane are turned by pi first.
    always_comb begin
        n_x0 = t_wide'(i_x) <<< PRE_SHIFT;
        n_y0 = t_wide'(i_y) <<< PRE_SHIFT;
        n_z0 = '0;
        if (n_x0 < 0) begin
            n_x0 = -n_x0;
            n_y0 = -n_y0;
            n_z0 = HALF_TURN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x0;
            r_y[0]    <= n_y0;
            r_z[0]    <= n_z0;
            r_zero[0] <= (i_x == '0) && (i_y == '0);
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_iter
        t_wide n_x;
        t_wide n_y;
        t_acc  n_z;

        always_comb begin
            if (!r_y[i][XW-1]) begin
                n_x = r_x[i] + (r_y[i] >>> i);
                n_y = r_y[i] - (r_x[i] >>> i);
                n_z = r_z[i] + ATAN_TAB[i];
            end else begin
                n_x = r_x[i] - (r_y[i] >>> i);
                n_y = r_y[i] + (r_x[i] >>> i);
                n_z = r_z[i] - ATAN_TAB[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i+1]    <= n_x;
                r_y[i+1]    <= n_y;
                r_z[i+1]    <= n_z;
                r_zero[i+1] <= r_zero[i];
            end
        end
    end

    // Round the 32-bit accumulator to a 16-bit binary angle.
    assign n_rnd   = r_z[STEPS] + ANGLE_RND;
    assign o_angle = r_zero[STEPS] ? '0 : n_rnd[ACC_W-1 -: ANGLE_W];

endmodule

[sv/bts_rotation.sv]
// ----------------------------------------------------------------------------
// CORDIC rotation pipeline
// Rotates a gain-compensated vector by a signed turn, one iteration per stage.
// ----------------------------------------------------------------------------
module bts_rotation import bts_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_wide i_x,
    input  t_wide i_y,
    input  t_turn i_turn,
    output t_wide o_x,
    output t_wide o_y
);

    t_wide r_x [0:STEPS];
    t_wide r_y [0:STEPS];
    t_rz   r_z [0:STEPS];

    t_wide n_x0;
    t_wide n_y0;
    t_turn n_t0;

    // Turns beyond a quarter circle negate the vector and move the turn by pi.
    always_comb begin
        n_x0 = i_x;
        n_y0 = i_y;
        n_t0 = i_turn;
        if (i_turn > QUARTER) begin
            n_x0 = -i_x;
            n_y0 = -i_y;
            n_t0 = i_turn - HALF;
        end else if (i_turn < -QUARTER) begin
            n_x0 = -i_x;
            n_y0 = -i_y;
            n_t0 = i_turn + HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= n_x0;
            r_y[0] <= n_y0;
            r_z[0] <= t_rz'(n_t0) <<< (ACC_W - ANGLE_W);
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_iter
        t_wide n_x;
        t_wide n_y;
        t_rz   n_z;
        t_rz   n_a;

        assign n_a = $signed({2'b00, ATAN_TAB[i]});

        always_comb begin
            if (!r_z[i][RZW-1]) begin
                n_x = r_x[i] - (r_y[i] >>> i);
                n_y = r_y[i] + (r_x[i] >>> i);
                n_z = r_z[i] - n_a;
            end else begin
                n_x = r_x[i] + (r_y[i] >>> i);
                n_y = r_y[i] - (r_x[i] >>> i);
                n_z = r_z[i] + n_a;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i+1] <= n_x;
                r_y[i+1] <= n_y;
                r_z[i+1] <= n_z;
            end
        end
    end

    assign o_x = r_x[STEPS];
    assign o_y = r_y[STEPS];

endmodule

[sv/bounded_turn_vector_steer.sv]
// ----------------------------------------------------------------------------
// Bounded turn vector steer
// Turns a heading vector toward a goal vector by at most a set angle per request.
// ----------------------------------------------------------------------------
// The block takes one request (heading and goal vector, signed Q8.8) per clock
// while the output is not stalled and returns one turned heading per request,
// in order. Each CORDIC iteration has a register stage of its own: two
// vectoring pipelines find the heading and goal angles side by side, one stage
// clamps the turn and applies the gain correction, and a rotation pipeline
// turns the heading. The whole pipeline holds while a result waits at the
// output and is not taken. The turn limit may be written at any time with no
// request in flight; it resets to 1024 (pi/32).
// ----------------------------------------------------------------------------
module bounded_turn_vector_steer import bts_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    bts_in_if.sink    i_in,
    bts_cfg_if.sink   i_cfg,
    bts_out_if.source o_out
);

    localparam int LAT       = 2 * STEPS + 4;
    localparam int ST_OUT    = LAT - 1;
    localparam int FIN_SHIFT = PRE_SHIFT;
    localparam int PROD_W    = COORD_WIDTH + GAIN_W;

    localparam logic signed [XW:0] FIN_RND = (XW+1)'(2 ** (FIN_SHIFT - 1));
    localparam logic signed [XW:0] SAT_HI  = (XW+1)'(2 ** (COORD_WIDTH - 1) - 1);
    localparam logic signed [XW:0] SAT_LO  = ~SAT_HI;

    logic               r_valid [0:LAT-1];
    logic [ANGLE_W-1:0] r_max;
    t_coord             r_hx [0:STEPS];
    t_coord             r_hy [0:STEPS];
    t_turn              r_turn;
    t_wide              r_px;
    t_wide              r_py;
    t_coord             r_out_x;
    t_coord             r_out_y;

    logic                    n_en;
    t_angle                  n_ah;
    t_angle                  n_ag;
    t_angle                  n_diff;
    logic signed [TURN_W:0]  n_d;
    logic signed [TURN_W:0]  n_lim;
    logic signed [TURN_W:0]  n_dc;
    logic signed [PROD_W-1:0] n_prod_x;
    logic signed [PROD_W-1:0] n_prod_y;
    t_wide                   n_rx;
    t_wide                   n_ry;

    function automatic t_coord f_finish(input t_wide v);
        logic signed [XW:0] s;
        begin
            s = ($signed({v[XW-1], v}) + FIN_RND) >>> FIN_SHIFT;
            if (s > SAT_HI) begin
                s = SAT_HI;
            end else if (s < SAT_LO) begin
                s = SAT_LO;
            end
            return t_coord'(s);
        end
    endfunction

    // Global stall: everything advances unless the output holds an untaken result.
    assign n_en        = !r_valid[ST_OUT] || o_out.ready;
    assign i_in.ready  = n_en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_TURN_RESET;
        end else if (i_cfg.valid) begin
            r_max <= i_cfg.max_turn_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (n_en) begin
            r_valid[0] <= i_in.valid;
            for (int k = 1; k < LAT; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    // The heading rides alongside the vectoring pipelines for the rotation.
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_hx[0] <= i_in.heading_x;
            r_hy[0] <= i_in.heading_y;
            for (int k = 1; k <= STEPS; k++) begin
                r_hx[k] <= r_hx[k-1];
                r_hy[k] <= r_hy[k-1];
            end
        end
    end

    bts_vectoring u_vec_head (
        .i_clk   (i_clk),
        .i_en    (n_en),
        .i_x     (i_in.heading_x),
        .i_y     (i_in.heading_y),
        .o_angle (n_ah)
    );

    bts_vectoring u_vec_goal (
        .i_clk   (i_clk),
        .i_en    (n_en),
        .i_x     (i_in.goal_x),
        .i_y     (i_in.goal_y),
        .o_angle (n_ag)
    );

    // Modular difference wraps the turn into [-pi, pi), then it is clamped.
    always_comb begin
        n_diff = n_ag - n_ah;
        n_d    = (TURN_W+1)'($signed(n_diff));
        n_lim  = $signed({2'b00, r_max});
        if (n_d > n_lim) begin
            n_dc = n_lim;
        end else if (n_d < -n_lim) begin
            n_dc = -n_lim;
        end else begin
            n_dc = n_d;
        end
    end

    assign n_prod_x = r_hx[STEPS] * INV_GAIN;
    assign n_prod_y = r_hy[STEPS] * INV_GAIN;

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_turn <= t_turn'(n_dc);
            r_px   <= XW'(n_prod_x >>> GAIN_SHIFT);
            r_py   <= XW'(n_prod_y >>> GAIN_SHIFT);
        end
    end

    bts_rotation u_rot (
        .i_clk  (i_clk),
        .i_en   (n_en),
        .i_x    (r_px),
        .i_y    (r_py),
        .i_turn (r_turn),
        .o_x    (n_rx),
        .o_y    (n_ry)
    );

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_out_x <= f_finish(n_rx);
            r_out_y <= f_finish(n_ry);
        end
    end

    assign o_out.valid    = r_valid[ST_OUT];
    assign o_out.turned_x = r_out_x;
    assign o_out.turned_y = r_out_y;

endmodule
